// ----- hw/rtl/mfpm_pkg.sv -----
package mfpm_pkg;

    // Default geometry and pattern count.
    localparam int FRAME_WIDTH_DEF  = 128;
    localparam int FRAME_HEIGHT_DEF = 32;
    localparam int NUM_PATTERNS_DEF = 32;

    // Counter and field widths.
    localparam int CNT_W   = 13;
    localparam int ID_W    = 16;
    localparam int CH_W    = 8;
    localparam int SLOT_W  = 5;
    localparam int FRAC_W  = 17;
    localparam int PROD_W  = 30;
    localparam int OUT_CNT_W = 6;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam int MAX_OUT = 32;

    // Pixel classification thresholds.
    localparam logic [CH_W-1:0] WILD_RB_MIN = 8'd200;
    localparam logic [CH_W-1:0] WILD_G_LIM  = 8'd100;
    localparam logic [CH_W-1:0] LIT_MIN     = 8'd32;

    // Fraction scale and rounding.
    localparam logic [FRAC_W-1:0] FRAC_ONE  = 17'd65536;
    localparam logic [PROD_W-1:0] ROUND_ADD = 30'd32768;

    // Configuration register indexes and reset values.
    localparam logic [1:0] CFG_MATCH_FRACTION = 2'd0;
    localparam logic [1:0] CFG_COLOR_TOL      = 2'd1;
    localparam logic [1:0] CFG_COMPARE_COLOR  = 2'd2;

    localparam logic [FRAC_W-1:0] FRAC_RESET = 17'd58982;
    localparam logic [CH_W-1:0]   TOL_RESET  = 8'd16;

    // Operation codes of an input word.
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_FRAME = 1'b1;

    // Result kinds.
    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_TRANS  = 1'b1;

    typedef struct packed {
        logic            care;
        logic            lit;
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_pix;

    typedef struct packed {
        logic [ID_W-1:0]  trigger;
        logic [CNT_W-1:0] care;
        logic [CNT_W-1:0] mism;
        logic [CNT_W-1:0] uni;
    } t_ent;

    typedef struct packed {
        logic rd;
        logic wr;
    } t_mem_ctl;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == CNT_MAX) ? CNT_MAX : v + 1'b1;
    endfunction

    function automatic logic [CH_W-1:0] abs_diff(input logic [CH_W-1:0] a,
                                                 input logic [CH_W-1:0] b);
        abs_diff = (a > b) ? a - b : b - a;
    endfunction

endpackage

// ----- hw/rtl/mfpm_pix_store.sv -----
module mfpm_pix_store #(
    parameter int FRAME_WIDTH  = mfpm_pkg::FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = mfpm_pkg::FRAME_HEIGHT_DEF,
    parameter int NUM_PATTERNS = mfpm_pkg::NUM_PATTERNS_DEF
) (
    input  logic                      i_clk,
    input  mfpm_pkg::t_mem_ctl        i_ctl,
    input  logic [$clog2(NUM_PATTERNS*FRAME_WIDTH*FRAME_HEIGHT)-1:0] i_addr,
    input  logic [mfpm_pkg::CH_W-1:0] i_red,
    input  logic [mfpm_pkg::CH_W-1:0] i_green,
    input  logic [mfpm_pkg::CH_W-1:0] i_blue,
    output mfpm_pkg::t_pix            o_pix
);

    localparam int DEPTH = NUM_PATTERNS * FRAME_WIDTH * FRAME_HEIGHT;

    mfpm_pkg::t_pix r_mem [DEPTH];
    mfpm_pkg::t_pix r_rd;
    mfpm_pkg::t_pix wr_pix;
    logic           wild;
    logic [mfpm_pkg::CH_W-1:0] max_ch;

    // Magenta marks a wildcard; other pixels are care pixels.
    always_comb begin
        wild = (i_red >= mfpm_pkg::WILD_RB_MIN) && (i_blue >= mfpm_pkg::WILD_RB_MIN)
               && (i_green < mfpm_pkg::WILD_G_LIM);
        max_ch = (i_red > i_green) ? i_red : i_green;
        if (i_blue > max_ch) begin
            max_ch = i_blue;
        end
        wr_pix = '0;
        if (!wild) begin
            wr_pix.care  = 1'b1;
            wr_pix.lit   = (max_ch >= mfpm_pkg::LIT_MIN);
            wr_pix.red   = i_red;
            wr_pix.green = i_green;
            wr_pix.blue  = i_blue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_mem[i_addr] <= wr_pix;
        end
        if (i_ctl.rd) begin
            r_rd <= r_mem[i_addr];
        end
    end

    assign o_pix = r_rd;

endmodule

// ----- hw/rtl/mfpm_slot_store.sv -----
module mfpm_slot_store #(
    parameter int NUM_PATTERNS = mfpm_pkg::NUM_PATTERNS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  mfpm_pkg::t_mem_ctl    i_ctl,
    input  logic [((NUM_PATTERNS > 1) ? $clog2(NUM_PATTERNS) : 1)-1:0] i_raddr,
    input  logic [((NUM_PATTERNS > 1) ? $clog2(NUM_PATTERNS) : 1)-1:0] i_waddr,
    input  mfpm_pkg::t_ent        i_wdata,
    output mfpm_pkg::t_ent        o_rdata
);

    mfpm_pkg::t_ent          r_mem [NUM_PATTERNS];
    mfpm_pkg::t_ent          r_rd;
    logic                    r_rd_ok;
    logic [NUM_PATTERNS-1:0] r_ok;

    // Mismatch and union counters of an entry never written read as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ok <= '0;
        end else if (i_ctl.wr) begin
            r_ok[i_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_ctl.rd) begin
            r_rd    <= r_mem[i_raddr];
            r_rd_ok <= r_ok[i_raddr];
        end
    end

    always_comb begin
        o_rdata = r_rd;
        if (!r_rd_ok) begin
            o_rdata.mism = '0;
            o_rdata.uni  = '0;
        end
    end

endmodule

// ----- hw/rtl/masked_frame_pattern_matcher.sv -----
// Masked frame pattern matcher.
// Input channel (i_valid / o_stall) carries one pixel word: a pattern load pixel
// (op 0, for slot i_slot, trigger i_pattern_id) or a live frame pixel (op 1).
// Both streams go in top-down raster order and share one position counter;
// i_last ends a pattern or a frame. Result words leave on o_valid / i_stall:
// one load status word at the end of each in-range pattern load, and at the end
// of a frame one word per pattern whose match state changed, in slot order,
// at most 32 per frame. The final word of each input carries o_last_result.
// A load pixel passes through the read state and the write state; the final load
// pixel then passes its status word on, waiting there while the receiver stalls.
// A frame pixel steps through every pattern slot, set by the single read port of the
// pattern pixel memory visited once per slot. The last frame pixel adds a scan
// through the counter memory (read, multiply, decide per slot) and a flush state.
// The output register holds one word and a second word waits inside, so a new
// input is taken while a result still waits; when the receiver stalls, the
// block waits only once it has a further word to hand over.
// Reset clears the position counter, all valid and match flags, the output valid flag
// and the configuration registers to defaults; pattern memory is undefined until loaded.
// Configuration writes are always taken and belong in idle periods only.
module masked_frame_pattern_matcher #(
    parameter int FRAME_WIDTH  = mfpm_pkg::FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = mfpm_pkg::FRAME_HEIGHT_DEF,
    parameter int NUM_PATTERNS = mfpm_pkg::NUM_PATTERNS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Pixel input channel.
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_op,
    input  logic [4:0]  i_slot,
    input  logic [15:0] i_pattern_id,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    input  logic [7:0]  i_luma,
    input  logic        i_last,
    // Result channel.
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_kind,
    output logic [15:0] o_trigger_id,
    output logic        o_matched,
    output logic        o_accepted,
    output logic        o_last_result,
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [16:0] i_cfg_data
);

    localparam int NPIX   = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int POS_W  = $clog2(NPIX + 1);
    localparam int PIX_AW = $clog2(NUM_PATTERNS * NPIX);
    localparam int SW     = (NUM_PATTERNS > 1) ? $clog2(NUM_PATTERNS) : 1;
    localparam int CNT_W  = mfpm_pkg::CNT_W;
    localparam logic [SW-1:0] LAST_P = SW'(NUM_PATTERNS - 1);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_LD_RD   = 4'd1;
    localparam logic [3:0] S_LD_WR   = 4'd2;
    localparam logic [3:0] S_LD_OUT  = 4'd3;
    localparam logic [3:0] S_FR_RUN  = 4'd4;
    localparam logic [3:0] S_FR_TAIL = 4'd5;
    localparam logic [3:0] S_SC_RD   = 4'd6;
    localparam logic [3:0] S_SC_MUL  = 4'd7;
    localparam logic [3:0] S_SC_DEC  = 4'd8;
    localparam logic [3:0] S_FLUSH   = 4'd9;

    function automatic logic [PIX_AW-1:0] pix_addr(input logic [SW-1:0] s,
                                                   input logic [POS_W-1:0] p);
        pix_addr = PIX_AW'(s) * PIX_AW'(NPIX) + PIX_AW'(p);
    endfunction

    logic [3:0]        r_state;
    logic [POS_W-1:0]  r_pos;
    logic [POS_W-1:0]  r_cur_pos;
    logic [4:0]        r_slot;
    logic [15:0]       r_pid;
    logic [7:0]        r_red;
    logic [7:0]        r_green;
    logic [7:0]        r_blue;
    logic [7:0]        r_luma;
    logic              r_last;

    logic [NUM_PATTERNS-1:0] r_valid;
    logic [NUM_PATTERNS-1:0] r_match;

    logic [SW-1:0]     r_p;
    logic [SW-1:0]     r_p1;
    logic              r_v1;

    logic [16:0]       r_frac;
    logic [7:0]        r_tol;
    logic              r_color;

    logic [mfpm_pkg::PROD_W-1:0] r_prod;
    logic [CNT_W-1:0]  r_mism;
    logic              r_cnt_zero;
    mfpm_pkg::t_ent    r_ent;
    logic              r_ok;

    logic [mfpm_pkg::OUT_CNT_W-1:0] r_nout;
    logic              r_pend_v;
    logic [15:0]       r_pend_id;
    logic              r_pend_m;

    logic              r_o_valid;
    logic              r_o_kind;
    logic [15:0]       r_o_id;
    logic              r_o_matched;
    logic              r_o_acc;
    logic              r_o_last;

    logic              accept;
    logic              out_free;
    logic              in_frame_cur;
    logic [SW-1:0]     slot_i;

    mfpm_pkg::t_mem_ctl pix_ctl;
    logic [PIX_AW-1:0]  pix_a;
    mfpm_pkg::t_pix     pix_rd;
    mfpm_pkg::t_mem_ctl ent_ctl;
    logic [SW-1:0]      ent_raddr;
    logic [SW-1:0]      ent_waddr;
    mfpm_pkg::t_ent     ent_wdata;
    mfpm_pkg::t_ent     ent_rd;

    // Frame compare of the pattern that was read in the previous cycle.
    logic              flit;
    logic              mm;
    logic              un;
    logic              upd;

    // Load counter update.
    logic [CNT_W-1:0]  care_old;
    logic [CNT_W-1:0]  care_new;
    logic              ld_care;

    // Decision of the scan.
    logic [16:0]       frac_cl;
    logic [16:0]       slack;
    logic [CNT_W-1:0]  cnt_sel;
    logic [mfpm_pkg::PROD_W-1:0] rounded;
    logic [CNT_W:0]    budget;
    logic              dec_m;
    logic              trans;
    logic              emit;
    logic              blocked;

    logic              out_ld;
    logic              out_kind;
    logic [15:0]       out_id;
    logic              out_m;
    logic              out_acc;
    logic              out_last;

    assign accept       = i_valid && !o_stall;
    assign o_stall      = (r_state != S_IDLE);
    assign out_free     = !r_o_valid || !i_stall;
    assign in_frame_cur = (r_cur_pos < POS_W'(NPIX));
    assign slot_i       = SW'(r_slot);
    assign o_cfg_ready  = 1'b1;

    mfpm_pix_store #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT),
        .NUM_PATTERNS (NUM_PATTERNS)
    ) u_pix (
        .i_clk   (i_clk),
        .i_ctl   (pix_ctl),
        .i_addr  (pix_a),
        .i_red   (r_red),
        .i_green (r_green),
        .i_blue  (r_blue),
        .o_pix   (pix_rd)
    );

    mfpm_slot_store #(
        .NUM_PATTERNS (NUM_PATTERNS)
    ) u_slot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ent_ctl),
        .i_raddr (ent_raddr),
        .i_waddr (ent_waddr),
        .i_wdata (ent_wdata),
        .o_rdata (ent_rd)
    );

    always_comb begin
        // Frame pixel against the stored pattern pixel.
        flit = (r_luma != '0);
        if (r_color) begin
            mm = (mfpm_pkg::abs_diff(r_red, pix_rd.red) > r_tol)
                 || (mfpm_pkg::abs_diff(r_green, pix_rd.green) > r_tol)
                 || (mfpm_pkg::abs_diff(r_blue, pix_rd.blue) > r_tol);
            un = 1'b0;
        end else begin
            mm = (flit != pix_rd.lit);
            un = flit || pix_rd.lit;
        end
        upd = r_v1 && r_valid[r_p1] && pix_rd.care;

        // Care count of the slot being loaded; position zero restarts it.
        ld_care  = !((r_red >= mfpm_pkg::WILD_RB_MIN) && (r_blue >= mfpm_pkg::WILD_RB_MIN)
                     && (r_green < mfpm_pkg::WILD_G_LIM));
        care_old = (r_cur_pos == '0) ? '0 : ent_rd.care;
        care_new = (ld_care && in_frame_cur) ? mfpm_pkg::sat_inc(care_old) : care_old;

        // Budget = round(count * (1 - fraction)).
        frac_cl = (r_frac > mfpm_pkg::FRAC_ONE) ? mfpm_pkg::FRAC_ONE : r_frac;
        slack   = mfpm_pkg::FRAC_ONE - frac_cl;
        cnt_sel = r_color ? ent_rd.care : ent_rd.uni;
        rounded = r_prod + mfpm_pkg::ROUND_ADD;
        budget  = rounded[mfpm_pkg::PROD_W-1:16];
        dec_m   = ({1'b0, r_mism} <= budget) && !(r_color && r_cnt_zero);
        trans   = r_valid[r_p] && (dec_m != r_match[r_p]);
        emit    = trans && (r_nout < mfpm_pkg::OUT_CNT_W'(mfpm_pkg::MAX_OUT));
        blocked = emit && r_pend_v && !out_free;

        pix_ctl   = '0;
        pix_a     = pix_addr(r_p, r_cur_pos);
        ent_ctl   = '0;
        ent_raddr = r_p;
        ent_waddr = r_p1;
        ent_wdata = ent_rd;

        out_ld   = 1'b0;
        out_kind = mfpm_pkg::KIND_TRANS;
        out_id   = r_pend_id;
        out_m    = r_pend_m;
        out_acc  = 1'b0;
        out_last = 1'b0;

        unique case (r_state)
            S_LD_RD: begin
                pix_ctl.wr = in_frame_cur;
                pix_a      = pix_addr(slot_i, r_cur_pos);
                ent_ctl.rd = 1'b1;
                ent_raddr  = slot_i;
            end
            S_LD_WR: begin
                ent_ctl.wr        = 1'b1;
                ent_waddr         = slot_i;
                ent_wdata.trigger = r_pid;
                ent_wdata.care    = care_new;
            end
            S_LD_OUT: begin
                out_ld   = out_free;
                out_kind = mfpm_pkg::KIND_STATUS;
                out_id   = r_pid;
                out_m    = 1'b0;
                out_acc  = r_ok;
                out_last = 1'b1;
            end
            S_FR_RUN, S_FR_TAIL: begin
                pix_ctl.rd = (r_state == S_FR_RUN);
                ent_ctl.rd = (r_state == S_FR_RUN);
                ent_ctl.wr = upd;
                if (mm) begin
                    ent_wdata.mism = mfpm_pkg::sat_inc(ent_rd.mism);
                end
                if (un) begin
                    ent_wdata.uni = mfpm_pkg::sat_inc(ent_rd.uni);
                end
            end
            S_SC_RD: begin
                ent_ctl.rd = 1'b1;
            end
            S_SC_DEC: begin
                ent_ctl.wr     = !blocked;
                ent_waddr      = r_p;
                ent_wdata      = r_ent;
                ent_wdata.mism = '0;
                ent_wdata.uni  = '0;
                out_ld         = emit && r_pend_v && out_free;
            end
            S_FLUSH: begin
                out_ld   = r_pend_v && out_free;
                out_last = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frac  <= mfpm_pkg::FRAC_RESET;
            r_tol   <= mfpm_pkg::TOL_RESET;
            r_color <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                mfpm_pkg::CFG_MATCH_FRACTION: r_frac  <= i_cfg_data;
                mfpm_pkg::CFG_COLOR_TOL:      r_tol   <= i_cfg_data[7:0];
                mfpm_pkg::CFG_COMPARE_COLOR:  r_color <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Input word, scan operand, load status and result payload capture; none needs reset.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_slot    <= i_slot;
            r_pid     <= i_pattern_id;
            r_red     <= i_red;
            r_green   <= i_green;
            r_blue    <= i_blue;
            r_luma    <= i_luma;
            r_last    <= i_last;
            r_cur_pos <= r_pos;
        end
        if (r_state == S_SC_MUL) begin
            r_prod     <= mfpm_pkg::PROD_W'(cnt_sel) * mfpm_pkg::PROD_W'(slack);
            r_mism     <= ent_rd.mism;
            r_cnt_zero <= (cnt_sel == '0);
            r_ent      <= ent_rd;
        end
        if (r_state == S_LD_WR) begin
            r_ok <= (care_new != '0);
        end
        if (out_ld) begin
            r_o_kind    <= out_kind;
            r_o_id      <= out_id;
            r_o_matched <= out_m;
            r_o_acc     <= out_acc;
            r_o_last    <= out_last;
        end
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pos     <= '0;
            r_valid   <= '0;
            r_match   <= '0;
            r_p       <= '0;
            r_p1      <= '0;
            r_v1      <= 1'b0;
            r_nout    <= '0;
            r_pend_v  <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (out_ld) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && !i_stall) begin
                r_o_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (i_last) begin
                            r_pos <= '0;
                        end else if (r_pos < POS_W'(NPIX)) begin
                            r_pos <= r_pos + 1'b1;
                        end
                        r_p      <= '0;
                        r_v1     <= 1'b0;
                        r_nout   <= '0;
                        r_pend_v <= 1'b0;
                        if (i_op == mfpm_pkg::OP_LOAD) begin
                            if (32'(i_slot) < NUM_PATTERNS) begin
                                r_state <= S_LD_RD;
                            end
                        end else if (r_pos < POS_W'(NPIX)) begin
                            r_state <= S_FR_RUN;
                        end else if (i_last) begin
                            r_state <= S_SC_RD;
                        end
                    end
                end
                S_LD_RD: begin
                    // A load restarting at position zero takes the slot offline.
                    if (r_cur_pos == '0) begin
                        r_valid[slot_i] <= 1'b0;
                        r_match[slot_i] <= 1'b0;
                    end
                    r_state <= S_LD_WR;
                end
                S_LD_WR: begin
                    if (r_last) begin
                        r_valid[slot_i] <= (care_new != '0);
                        r_match[slot_i] <= 1'b0;
                        r_state         <= S_LD_OUT;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_LD_OUT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                S_FR_RUN: begin
                    r_p1 <= r_p;
                    r_v1 <= 1'b1;
                    if (r_p == LAST_P) begin
                        r_state <= S_FR_TAIL;
                    end else begin
                        r_p <= r_p + 1'b1;
                    end
                end
                S_FR_TAIL: begin
                    r_v1 <= 1'b0;
                    r_p  <= '0;
                    r_state <= r_last ? S_SC_RD : S_IDLE;
                end
                S_SC_RD: begin
                    r_state <= S_SC_MUL;
                end
                S_SC_MUL: begin
                    r_state <= S_SC_DEC;
                end
                S_SC_DEC: begin
                    if (!blocked) begin
                        if (trans) begin
                            r_match[r_p] <= dec_m;
                        end
                        if (emit) begin
                            // The newest transition waits so the final one can be flagged.
                            r_pend_v  <= 1'b1;
                            r_pend_id <= r_ent.trigger;
                            r_pend_m  <= dec_m;
                            r_nout    <= r_nout + 1'b1;
                        end
                        if (r_p == LAST_P) begin
                            r_state <= S_FLUSH;
                        end else begin
                            r_p     <= r_p + 1'b1;
                            r_state <= S_SC_RD;
                        end
                    end
                end
                S_FLUSH: begin
                    if (!r_pend_v) begin
                        r_state <= S_IDLE;
                    end else if (out_free) begin
                        r_pend_v <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid       = r_o_valid;
    assign o_kind        = r_o_kind;
    assign o_trigger_id  = r_o_id;
    assign o_matched     = r_o_matched;
    assign o_accepted    = r_o_acc;
    assign o_last_result = r_o_last;

endmodule

// ----- hw/rtl/mfpm_checker.sv -----
module mfpm_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_valid,
    input logic i_stall,
    input logic o_kind,
    input logic o_matched,
    input logic o_accepted,
    input logic o_last_result
);

    // A stalled result word stays offered.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result word dropped while stalled");

    // Reset empties the result register.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result word present after reset");

    // A load status word is always the last word of its input and claims no match.
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_kind |-> o_last_result && !o_matched)
        else $error("load status word malformed");

    // Transitions never claim a stored pattern.
    a_trans_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind |-> !o_accepted)
        else $error("transition word carries load status");

endmodule

bind masked_frame_pattern_matcher mfpm_checker u_mfpm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_kind        (o_kind),
    .o_matched     (o_matched),
    .o_accepted    (o_accepted),
    .o_last_result (o_last_result)
);

// ----- tb/sv/masked_frame_pattern_matcher_test.sv -----
`timescale 1ns / 1ps

module masked_frame_pattern_matcher_test;

    localparam int NP   = mfpm_pkg::NUM_PATTERNS_DEF;
    localparam int NPIX = mfpm_pkg::FRAME_WIDTH_DEF * mfpm_pkg::FRAME_HEIGHT_DEF;
    localparam int CW   = mfpm_pkg::CNT_W;
    // Short streams: every pattern load writes at least SHORT_LEN pixels and
    // every short frame reads at most SHORT_LEN, so no frame ever touches a
    // pattern pixel that was never written.
    localparam int SHORT_LEN = 4;
    // Longest busy stretch after the last result: a frame end scan over every
    // pattern, plus a frame pixel pass.
    localparam int DRAIN_CYCLES = 3 * NP + NP + 2 + 200;

    // One pixel word as it goes into the block.
    typedef struct {
        logic        op;
        logic [4:0]  slot;
        logic [15:0] id;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  luma;
        logic        last;
    } pix_word_t;

    // One result word as it leaves the block.
    typedef struct {
        logic        kind;
        logic [15:0] trigger_id;
        logic        matched;
        logic        accepted;
        logic        last_result;
    } event_word_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic        i_op;
    logic [4:0]  i_slot;
    logic [15:0] i_pattern_id;
    logic [7:0]  i_red;
    logic [7:0]  i_green;
    logic [7:0]  i_blue;
    logic [7:0]  i_luma;
    logic        i_last;
    logic        o_valid;
    logic        i_stall;
    logic        o_kind;
    logic [15:0] o_trigger_id;
    logic        o_matched;
    logic        o_accepted;
    logic        o_last_result;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [16:0] i_cfg_data;

    masked_frame_pattern_matcher i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_op          (i_op),
        .i_slot        (i_slot),
        .i_pattern_id  (i_pattern_id),
        .i_red         (i_red),
        .i_green       (i_green),
        .i_blue        (i_blue),
        .i_luma        (i_luma),
        .i_last        (i_last),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_kind        (o_kind),
        .o_trigger_id  (o_trigger_id),
        .o_matched     (o_matched),
        .o_accepted    (o_accepted),
        .o_last_result (o_last_result),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // Words waiting to be sent, and results the matcher model says must come.
    pix_word_t   pending_words[$];
    event_word_t expected_events[$];

    // Matcher model state, updated as each word is accepted.
    mfpm_pkg::t_pix  pat_mem [0:NP*NPIX-1];
    logic            slot_valid [0:NP-1];
    logic [15:0]     slot_trigger [0:NP-1];
    logic [CW-1:0]   slot_care [0:NP-1];
    logic            slot_matched [0:NP-1];
    logic [CW-1:0]   slot_mism [0:NP-1];
    logic [CW-1:0]   slot_union [0:NP-1];
    int              position;
    logic [16:0]     frac_reg;
    logic [7:0]      tol_reg;
    logic            color_reg;

    // What the stimulus generator already planned for each slot, so that
    // frames can be built that resemble a stored pattern.
    mfpm_pkg::t_pix plan_pix [0:NP-1][0:SHORT_LEN-1];

    int  errors;
    bit  quiet;        // no idling on either side in the last part of the run
    bit  took;         // input word accepted at the last rising edge
    int  gap_left;
    int  stall_left;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("RESULT: ERROR");
        $finish;
    end

    // Classify a pattern pixel: magenta is a wildcard, anything else is a care
    // pixel that keeps its color and is lit when its brightest channel is high.
    function automatic mfpm_pkg::t_pix pattern_entry(input logic [7:0] r,
                                                     input logic [7:0] g,
                                                     input logic [7:0] b);
        mfpm_pkg::t_pix e;
        e = '0;
        if (!(r >= mfpm_pkg::WILD_RB_MIN && b >= mfpm_pkg::WILD_RB_MIN
              && g < mfpm_pkg::WILD_G_LIM)) begin
            e.care  = 1'b1;
            e.lit   = (r >= mfpm_pkg::LIT_MIN) || (g >= mfpm_pkg::LIT_MIN)
                      || (b >= mfpm_pkg::LIT_MIN);
            e.red   = r;
            e.green = g;
            e.blue  = b;
        end
        return e;
    endfunction

    function automatic logic [CW-1:0] bump(input logic [CW-1:0] v);
        return (v == mfpm_pkg::CNT_MAX) ? v : v + 1'b1;
    endfunction

    function automatic logic [7:0] dist8(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    // Advance the matcher model by one accepted word and queue the results it
    // causes; the final one of the word carries the last-result flag.
    task automatic step_matcher(input pix_word_t w);
        event_word_t    ev;
        event_word_t    burst[$];
        mfpm_pkg::t_pix e;
        bit             inframe;
        bit             m;
        longint         cnt;
        longint         budget;
        longint         slack;
        begin
            inframe = position < NPIX;
            if (w.op == mfpm_pkg::OP_LOAD) begin
                if (w.slot < NP) begin
                    if (position == 0) begin
                        slot_valid[w.slot]   = 1'b0;
                        slot_matched[w.slot] = 1'b0;
                        slot_care[w.slot]    = '0;
                    end
                    slot_trigger[w.slot] = w.id;
                    if (inframe) begin
                        e = pattern_entry(w.red, w.green, w.blue);
                        if (e.care)
                            slot_care[w.slot] = bump(slot_care[w.slot]);
                        pat_mem[w.slot * NPIX + position] = e;
                    end
                    if (w.last) begin
                        slot_valid[w.slot]   = slot_care[w.slot] != 0;
                        slot_matched[w.slot] = 1'b0;
                        ev.kind        = mfpm_pkg::KIND_STATUS;
                        ev.trigger_id  = slot_trigger[w.slot];
                        ev.matched     = 1'b0;
                        ev.accepted    = slot_valid[w.slot];
                        ev.last_result = 1'b0;
                        burst.insert(burst.size(), ev);
                    end
                end
            end else begin
                if (inframe) begin
                    for (int p = 0; p < NP; p++) begin
                        e = pat_mem[p * NPIX + position];
                        if (slot_valid[p] && e.care) begin
                            if (color_reg) begin
                                if (dist8(w.red, e.red) > tol_reg ||
                                    dist8(w.green, e.green) > tol_reg ||
                                    dist8(w.blue, e.blue) > tol_reg)
                                    slot_mism[p] = bump(slot_mism[p]);
                            end else begin
                                if ((w.luma != 0) != e.lit)
                                    slot_mism[p] = bump(slot_mism[p]);
                                if ((w.luma != 0) || e.lit)
                                    slot_union[p] = bump(slot_union[p]);
                            end
                        end
                    end
                end
                if (w.last) begin
                    // A fraction above one counts as exactly one.
                    slack = 65536 - ((frac_reg > 65536) ? 65536 : frac_reg);
                    for (int p = 0; p < NP; p++) begin
                        if (slot_valid[p]) begin
                            cnt    = color_reg ? slot_care[p] : slot_union[p];
                            budget = (cnt * slack + 32768) >> 16;
                            m      = slot_mism[p] <= budget;
                            if (color_reg && cnt == 0)
                                m = 1'b0;
                            if (m != slot_matched[p]) begin
                                slot_matched[p] = m;
                                // Only the first MAX_OUT changes are reported.
                                if (burst.size() < mfpm_pkg::MAX_OUT) begin
                                    ev.kind        = mfpm_pkg::KIND_TRANS;
                                    ev.trigger_id  = slot_trigger[p];
                                    ev.matched     = m;
                                    ev.accepted    = 1'b0;
                                    ev.last_result = 1'b0;
                                    burst.insert(burst.size(), ev);
                                end
                            end
                        end
                        slot_mism[p]  = '0;
                        slot_union[p] = '0;
                    end
                end
            end
            // The counter holds past the frame size and restarts on any last pixel.
            if (w.last)
                position = 0;
            else if (inframe)
                position = position + 1;
            if (burst.size() > 0)
                burst[burst.size() - 1].last_result = 1'b1;
            foreach (burst[k])
                expected_events.insert(expected_events.size(), burst[k]);
        end
    endtask

    task automatic queue_word(input logic op, input logic [4:0] slot, input logic [15:0] id,
                              input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                              input logic [7:0] luma, input logic last);
        pix_word_t w;
        begin
            w.op = op; w.slot = slot; w.id = id;
            w.red = r; w.green = g; w.blue = b;
            w.luma = luma; w.last = last;
            pending_words.insert(pending_words.size(), w);
        end
    endtask

    // Pattern pixel styles: 0 mixed, 1 dark care, 2 wildcard only.
    task automatic queue_load(input logic [4:0] slot, input logic [15:0] id, input int len,
                              input int style);
        logic [7:0] r, g, b;
        int         pick;
        begin
            for (int i = 0; i < len; i++) begin
                pick = (style == 0) ? $urandom_range(0, 3) : style;
                case (pick)
                    2: begin
                        r = 8'($urandom_range(200, 255));
                        g = 8'($urandom_range(0, 99));
                        b = 8'($urandom_range(200, 255));
                    end
                    1: begin
                        r = 8'($urandom_range(0, 31));
                        g = 8'($urandom_range(0, 31));
                        b = 8'($urandom_range(0, 31));
                    end
                    default: begin
                        r = 8'($urandom);
                        g = 8'($urandom);
                        b = 8'($urandom);
                    end
                endcase
                if (i < SHORT_LEN)
                    plan_pix[slot][i] = pattern_entry(r, g, b);
                queue_word(mfpm_pkg::OP_LOAD, slot, id, r, g, b, 8'($urandom), i == len - 1);
            end
        end
    endtask

    // A pixel that mostly agrees with a pattern pixel, both in lit shape and
    // in color, with a small random color drift.
    task automatic queue_near_pixel(input mfpm_pkg::t_pix e, input int agree_pct,
                                    input bit last);
        logic [7:0] luma;
        int         dr, dg, db;
        begin
            if (e.care && $urandom_range(1, 100) <= agree_pct) begin
                luma = e.lit ? 8'($urandom_range(1, 255)) : 8'd0;
                dr = int'(e.red) + $urandom_range(0, 40) - 20;
                dg = int'(e.green) + $urandom_range(0, 40) - 20;
                db = int'(e.blue) + $urandom_range(0, 40) - 20;
                dr = dr < 0 ? 0 : (dr > 255 ? 255 : dr);
                dg = dg < 0 ? 0 : (dg > 255 ? 255 : dg);
                db = db < 0 ? 0 : (db > 255 ? 255 : db);
                queue_word(mfpm_pkg::OP_FRAME, 5'($urandom), 16'($urandom),
                           8'(dr), 8'(dg), 8'(db), luma, last);
            end else begin
                luma = $urandom_range(0, 1) ? 8'($urandom) : 8'd0;
                queue_word(mfpm_pkg::OP_FRAME, 5'($urandom), 16'($urandom), 8'($urandom),
                           8'($urandom), 8'($urandom), luma, last);
            end
        end
    endtask

    task automatic queue_short_frame(input int agree_pct);
        int slot;
        int len;
        begin
            slot = $urandom_range(0, NP - 1);
            len  = $urandom_range(1, SHORT_LEN);
            for (int i = 0; i < len; i++)
                queue_near_pixel(plan_pix[slot][i], agree_pct, i == len - 1);
        end
    endtask

    // Mostly well-formed loads and frames that resemble stored patterns, with
    // some pure noise frames and all-wildcard loads mixed in.
    task automatic queue_random(input int words);
        int goal;
        int pick;
        begin
            goal = pending_words.size() + words;
            while (pending_words.size() < goal) begin
                pick = $urandom_range(0, 99);
                if (pick < 60)
                    queue_short_frame($urandom_range(70, 100));
                else if (pick < 72)
                    queue_short_frame(0);
                else if (pick < 96)
                    queue_load(5'($urandom), 16'($urandom),
                               $urandom_range(SHORT_LEN, SHORT_LEN + 4), 0);
                else
                    queue_load(5'($urandom), 16'($urandom), SHORT_LEN, 2);
            end
        end
    endtask

    // Let every queued word go in, every result come out, and the block go idle.
    task automatic settle();
        begin
            wait (pending_words.size() == 0 && !i_valid);
            wait (expected_events.size() == 0);
            repeat (DRAIN_CYCLES) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [16:0] value);
        begin
            @(negedge i_clk);
            i_cfg_valid <= 1'b1;
            i_cfg_index <= index;
            i_cfg_data  <= value;
            do @(posedge i_clk); while (!o_cfg_ready);
            case (index)
                mfpm_pkg::CFG_MATCH_FRACTION: frac_reg  = value;
                mfpm_pkg::CFG_COLOR_TOL:      tol_reg   = value[7:0];
                mfpm_pkg::CFG_COMPARE_COLOR:  color_reg = value[0];
                default: ;
            endcase
            @(negedge i_clk);
            i_cfg_valid <= 1'b0;
        end
    endtask

    task automatic set_mode(input logic [16:0] frac, input logic [7:0] tol, input logic color);
        begin
            write_reg(mfpm_pkg::CFG_MATCH_FRACTION, frac);
            write_reg(mfpm_pkg::CFG_COLOR_TOL, {9'd0, tol});
            write_reg(mfpm_pkg::CFG_COMPARE_COLOR, {16'd0, color});
        end
    endtask

    // Sender: a new word is put on the bus at the falling edge once the
    // previous one was taken, with random bursts of idle cycles between words.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_valid || took) begin
                if (gap_left > 0) begin
                    gap_left = gap_left - 1;
                    i_valid <= 1'b0;
                end else if (!quiet && $urandom_range(0, 5) == 0) begin
                    gap_left = $urandom_range(0, 7);
                    i_valid <= 1'b0;
                end else if (pending_words.size() > 0) begin
                    i_valid      <= 1'b1;
                    i_op         <= pending_words[0].op;
                    i_slot       <= pending_words[0].slot;
                    i_pattern_id <= pending_words[0].id;
                    i_red        <= pending_words[0].red;
                    i_green      <= pending_words[0].green;
                    i_blue       <= pending_words[0].blue;
                    i_luma       <= pending_words[0].luma;
                    i_last       <= pending_words[0].last;
                    void'(pending_words.pop_front());
                end else begin
                    i_valid <= 1'b0;
                end
            end
            took = 1'b0;

            // Receiver stalls in random bursts as well.
            if (stall_left > 0) begin
                stall_left = stall_left - 1;
                i_stall <= 1'b1;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 7);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Each accepted pixel word drives the model.
    always @(posedge i_clk) begin
        pix_word_t w;
        if (i_rst_n && i_valid && !o_stall) begin
            w.op = i_op; w.slot = i_slot; w.id = i_pattern_id;
            w.red = i_red; w.green = i_green; w.blue = i_blue;
            w.luma = i_luma; w.last = i_last;
            step_matcher(w);
            took = 1'b1;
        end
    end

    // Each accepted result word is checked against the oldest expectation.
    always @(posedge i_clk) begin
        event_word_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_events.size() == 0) begin
                errors = errors + 1;
                if (errors <= 10)
                    $display({"unexpected result word: kind %0d id %0d matched %0d",
                              " acc %0d last %0d"},
                             o_kind, o_trigger_id, o_matched, o_accepted, o_last_result);
            end else begin
                want = expected_events.pop_front();
                if (o_kind !== want.kind || o_trigger_id !== want.trigger_id ||
                    o_matched !== want.matched || o_accepted !== want.accepted ||
                    o_last_result !== want.last_result) begin
                    errors = errors + 1;
                    if (errors <= 10)
                        $display({"result mismatch: expected kind %0d id %0d matched %0d",
                                  " acc %0d last %0d, got kind %0d id %0d matched %0d",
                                  " acc %0d last %0d"},
                                 want.kind, want.trigger_id, want.matched, want.accepted,
                                 want.last_result, o_kind, o_trigger_id, o_matched,
                                 o_accepted, o_last_result);
                end
            end
        end
    end

    initial begin
        errors = 0; quiet = 1'b0; took = 1'b0; gap_left = 0; stall_left = 0;
        i_rst_n = 1'b0; i_valid = 1'b0; i_stall = 1'b0;
        i_op = mfpm_pkg::OP_LOAD; i_slot = '0; i_pattern_id = '0;
        i_red = '0; i_green = '0; i_blue = '0; i_luma = '0; i_last = 1'b0;
        i_cfg_valid = 1'b0; i_cfg_index = mfpm_pkg::CFG_MATCH_FRACTION; i_cfg_data = '0;
        for (int p = 0; p < NP; p++) begin
            slot_valid[p] = 1'b0; slot_matched[p] = 1'b0;
            slot_mism[p] = '0; slot_union[p] = '0;
            slot_care[p] = '0; slot_trigger[p] = '0;
        end
        position  = 0;
        frac_reg  = mfpm_pkg::FRAC_RESET;
        tol_reg   = mfpm_pkg::TOL_RESET;
        color_reg = 1'b0;

        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Every slot gets a dark pattern, so an all-dark frame matches all of
        // them at once and an all-lit frame releases all of them: each frame
        // end hits the limit of reported transitions.
        for (int s = 0; s < NP; s++)
            queue_load(s[4:0], 16'($urandom), SHORT_LEN, 1);
        for (int i = 0; i < SHORT_LEN; i++)
            queue_word(mfpm_pkg::OP_FRAME, 5'd31, 16'hffff, 8'd0, 8'd0, 8'd0, 8'd0,
                       i == SHORT_LEN - 1);
        for (int i = 0; i < SHORT_LEN; i++)
            queue_word(mfpm_pkg::OP_FRAME, 5'd0, 16'h0000, 8'hff, 8'hff, 8'hff, 8'hff,
                       i == SHORT_LEN - 1);

        // Classification edges: wildcard exactly at its limits, a near-miss on
        // each channel, and the lit threshold from both sides.
        queue_word(mfpm_pkg::OP_LOAD, 5'd3, 16'hffff, 8'd200, 8'd99, 8'd200, 8'd0, 1'b0);
        queue_word(mfpm_pkg::OP_LOAD, 5'd3, 16'hffff, 8'd199, 8'd99, 8'd200, 8'd0, 1'b0);
        queue_word(mfpm_pkg::OP_LOAD, 5'd3, 16'hffff, 8'd200, 8'd100, 8'd200, 8'd0, 1'b0);
        queue_word(mfpm_pkg::OP_LOAD, 5'd3, 16'hffff, 8'd200, 8'd99, 8'd199, 8'd0, 1'b0);
        queue_word(mfpm_pkg::OP_LOAD, 5'd3, 16'hffff, 8'd31, 8'd31, 8'd31, 8'd0, 1'b0);
        queue_word(mfpm_pkg::OP_LOAD, 5'd3, 16'hffff, 8'd0, 8'd32, 8'd0, 8'd0, 1'b0);
        queue_word(mfpm_pkg::OP_LOAD, 5'd3, 16'hffff, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
        queue_word(mfpm_pkg::OP_LOAD, 5'd3, 16'hffff, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
        plan_pix[3][0] = pattern_entry(8'd200, 8'd99, 8'd200);
        plan_pix[3][1] = pattern_entry(8'd199, 8'd99, 8'd200);
        plan_pix[3][2] = pattern_entry(8'd200, 8'd100, 8'd200);
        plan_pix[3][3] = pattern_entry(8'd200, 8'd99, 8'd199);
        // A pattern made only of wildcards is rejected.
        queue_load(5'd4, 16'h0000, SHORT_LEN, 2);

        queue_random(40);
        settle();

        // Strict fraction of exactly one with exact color compare.
        set_mode(17'd65536, 8'd0, 1'b1);
        queue_random(40);
        settle();

        // Fraction register at its top value acts as one; widest tolerance.
        set_mode(17'h1ffff, 8'd255, 1'b0);
        queue_random(30);
        settle();

        // Zero fraction: the budget is the whole count.
        set_mode(17'd0, 8'($urandom), 1'b1);
        queue_random(30);
        settle();

        // Random settings, and the last part of the run without any idling.
        set_mode(17'($urandom_range(0, 65536)), 8'($urandom), 1'($urandom));
        quiet = 1'b1;
        queue_random(30);
        settle();

        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- masked_frame_pattern_matcher.f -----
hw/rtl/mfpm_pkg.sv
hw/rtl/mfpm_pix_store.sv
hw/rtl/mfpm_slot_store.sv
hw/rtl/masked_frame_pattern_matcher.sv
hw/rtl/mfpm_checker.sv
tb/sv/masked_frame_pattern_matcher_test.sv
